[hw/rtl/lase_pkg.sv]
package lase_pkg;

	// Field widths
	localparam int POS_W    = 20;
	localparam int DIFF_W   = 21;
	localparam int AXIS_W   = 16;
	localparam int CHARGE_W = 16;
	localparam int RADIUS_W = 18;
	localparam int CNT_W    = 13;
	localparam int MEAN_W   = 16;
	localparam int SUM_W    = 32;

	// Stream and configuration packing
	localparam int S_DATA_W = 80;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 32;
	localparam int M_USER_W = 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CORE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CORE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KAPPA  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd7;

	// Datapath widths
	localparam int DOT_W   = 38;
	localparam int PROJ_W  = 24;
	localparam int DIST_W  = 43;
	localparam int LOG_IN_W = 42;
	localparam int LOG_E_W  = 6;
	localparam int LOG10_W  = 18;
	localparam int KT_W     = 28;
	localparam int TERM_W   = 34;
	localparam int MUL_A_W  = 35;
	localparam int MUL_B_W  = 25;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int DIV_NUM_W = SUM_W + 1;
	localparam int DIV_DEN_W = CNT_W + 1;

	// Arithmetic constants
	localparam logic signed [MUL_A_W-1:0] LOG10_2_Q32 = 35'sd1292913987;
	localparam logic [MUL_P_W-1:0] NEAR_LIMIT_SQ = 60'd1024000000;
	localparam logic [CHARGE_W-1:0] SAT_CHARGE = 16'd48000;
	localparam logic [CNT_W-1:0] MIN_USED = 13'd5;
	localparam logic [CNT_W-1:0] CNT_LIMIT = 13'd8191;
	localparam int KAPPA_SHIFT = 24;
	localparam int PROJ_SHIFT  = 14;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIFF, ST_M_NX, ST_M_NY, ST_M_NZ, ST_M_XX, ST_M_YY, ST_M_ZZ,
		ST_PROJ, ST_M_PP, ST_SEL, ST_LQ, ST_LQ_W, ST_LR, ST_LR_W, ST_LP, ST_LP_W,
		ST_CV_Q, ST_CV_R, ST_LOGR, ST_K1, ST_K2, ST_KT, ST_SUM, ST_FIN, ST_DIV,
		ST_DIV_W, ST_EMIT
	} lase_state_t;

	typedef enum logic [3:0] {
		MS_NONE, MS_NX, MS_NY, MS_NZ, MS_XX, MS_YY, MS_ZZ, MS_PP, MS_LQ, MS_LR,
		MS_K1, MS_K2
	} mul_sel_t;

	typedef enum logic [3:0] {
		AC_NONE, AC_DOT_SET, AC_DOT_ADD, AC_DIST_SET, AC_DIST_ADD, AC_LOGQ,
		AC_LOGR, AC_KT, AC_SUM
	} acc_sel_t;

	typedef enum logic [1:0] {LS_Q, LS_R0, LS_P} log_src_t;

	typedef enum logic [1:0] {LC_NONE, LC_Q, LC_R0, LC_P} log_cap_t;

	typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQ} log_state_t;

	typedef struct packed {
		logic      load_in;
		logic      load_diff;
		logic      load_proj;
		logic      load_p;
		mul_sel_t  mul;
		acc_sel_t  acc;
		logic      log_start;
		log_src_t  log_src;
		log_cap_t  log_cap;
		logic      count;
		logic      zero;
		logic      div_start;
		logic      emit;
	} lase_cmd_t;

	typedef struct packed {
		logic sel_pass;
		logic q_zero;
		logic last;
		logic log_done;
		logic div_done;
		logic out_free;
	} lase_sts_t;

	// Shift right by s, rounding half away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
		logic [63:0] mag;
		mag = v[63] ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (s - 1))) >> s;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

[hw/rtl/lase_log.sv]
module lase_log #(
	parameter int FRAC_BITS = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [lase_pkg::LOG_IN_W-1:0]             x,
	output logic                                     done,
	output logic [lase_pkg::LOG_E_W+FRAC_BITS-1:0]    result
);

	localparam int XW   = lase_pkg::LOG_IN_W;
	localparam int IT_W = $clog2(FRAC_BITS);

	lase_pkg::log_state_t state_q;
	logic [XW-1:0]               x_q;
	logic [lase_pkg::LOG_E_W-1:0] e_q;
	logic [30:0]                 m_q;
	logic [FRAC_BITS-1:0]        frac_q;
	logic [IT_W-1:0]             it_q;
	logic                        done_q;
	logic [61:0]                 sq;
	logic [31:0]                 sq_top;

	// Square the Q1.30 mantissa
	assign sq     = m_q * m_q;
	assign sq_top = sq[61:30];

	// Control: normalize, then one fraction bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lase_pkg::LG_IDLE;
			it_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				lase_pkg::LG_IDLE: begin
					if (start) state_q <= lase_pkg::LG_NORM;
				end
				lase_pkg::LG_NORM: begin
					if (x_q[XW-1]) begin
						state_q <= lase_pkg::LG_SQ;
						it_q    <= '0;
					end
				end
				lase_pkg::LG_SQ: begin
					if (it_q == IT_W'(FRAC_BITS - 1)) begin
						state_q <= lase_pkg::LG_IDLE;
						done_q  <= 1'b1;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				default: state_q <= lase_pkg::LG_IDLE;
			endcase
		end
	end

	// Data: shift by eight while the top byte is clear, else by one
	always_ff @(posedge clk) begin
		case (state_q)
			lase_pkg::LG_IDLE: begin
				if (start) begin
					x_q    <= x;
					e_q    <= lase_pkg::LOG_E_W'(XW - 1);
					frac_q <= '0;
				end
			end
			lase_pkg::LG_NORM: begin
				if (x_q[XW-1]) begin
					m_q <= x_q[XW-1 -: 31];
				end else if (x_q[XW-1 -: 8] == 8'd0) begin
					x_q <= x_q << 8;
					e_q <= e_q - lase_pkg::LOG_E_W'(8);
				end else begin
					x_q <= x_q << 1;
					e_q <= e_q - 1'b1;
				end
			end
			lase_pkg::LG_SQ: begin
				if (sq_top[31]) begin
					m_q    <= sq_top[31:1];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					m_q    <= sq_top[30:0];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = {e_q, frac_q};

endmodule

[hw/rtl/lase_div.sv]
module lase_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int IT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [IT_W-1:0]  it_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// One restoring step per cycle
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				if (it_q == IT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hw/rtl/lase_dp.sv]
module lase_dp #(
	parameter int LOG_TABLE_BITS = 10,
	parameter int MAX_PULSES     = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [lase_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lase_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [lase_pkg::S_DATA_W-1:0]       s_tdata,
	input  logic [lase_pkg::S_USER_W-1:0]       s_tuser,
	input  logic                                s_tlast,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [lase_pkg::M_DATA_W-1:0]       m_tdata,
	output logic [lase_pkg::M_USER_W-1:0]       m_tuser,
	input  lase_pkg::lase_cmd_t                 cmd,
	output lase_pkg::lase_sts_t                 sts
);

	localparam int LOG_W = lase_pkg::LOG_E_W + LOG_TABLE_BITS;
	localparam int L2S_W = LOG_W + 2;
	localparam int CW    = lase_pkg::CNT_W;
	localparam logic [CW-1:0] CNT_CAP = (MAX_PULSES > 8191) ? lase_pkg::CNT_LIMIT
		: CW'(MAX_PULSES);
	localparam logic signed [L2S_W-1:0] LOG_Q_OFS = L2S_W'(4 << LOG_TABLE_BITS);

	// Configuration registers
	logic signed [lase_pkg::POS_W-1:0]  core_x_q, core_y_q, core_z_q;
	logic signed [lase_pkg::AXIS_W-1:0] axis_nx_q, axis_ny_q, axis_nz_q, kappa_q;
	logic [lase_pkg::RADIUS_W-1:0]      radius_q;

	// Pulse registers
	logic signed [lase_pkg::POS_W-1:0]  sx_q, sy_q, sz_q;
	logic [lase_pkg::CHARGE_W-1:0]      q_q;
	logic                               qok_q, tok_q, last_q;
	logic signed [lase_pkg::DIFF_W-1:0] dx_q, dy_q, dz_q;
	logic signed [lase_pkg::DOT_W-1:0]  dot_q;
	logic [lase_pkg::DIST_W-1:0]        dist_q;
	logic signed [lase_pkg::PROJ_W-1:0] proj_q;
	logic [lase_pkg::LOG_IN_W-1:0]      p_q;
	logic [LOG_W-1:0]                   l2q_q, l2r0_q, l2p_q;
	logic signed [lase_pkg::LOG10_W-1:0] logq_q, logr_q;
	logic signed [lase_pkg::KT_W-1:0]   kt_q;
	logic signed [lase_pkg::MUL_P_W-1:0] prod_q;

	// Event state
	logic signed [lase_pkg::SUM_W-1:0]  log_sum_q;
	logic [CW-1:0]                      used_cnt_q;
	logic                               zero_seen_q;

	// Result register
	logic                               m_valid_q;
	logic [lase_pkg::MEAN_W-1:0]        mean_q;
	logic [CW-1:0]                      cnt_out_q;
	logic                               est_valid_q;

	logic signed [lase_pkg::MUL_A_W-1:0] mul_a;
	logic signed [lase_pkg::MUL_B_W-1:0] mul_b;
	logic signed [lase_pkg::MUL_P_W-1:0] mul_p;
	logic signed [L2S_W-1:0]             l2q_s, l2r_s;
	logic [lase_pkg::MUL_P_W-1:0]        dist_u, proj2_u, p_diff;
	logic                                sel_pass;
	logic [lase_pkg::LOG_IN_W-1:0]       log_x;
	logic                                log_done;
	logic [LOG_W-1:0]                    log_res;
	logic [lase_pkg::RADIUS_W-1:0]       r0_eff;
	logic signed [lase_pkg::TERM_W-1:0]  term, sum_w;
	logic [lase_pkg::SUM_W-1:0]          mag;
	logic [lase_pkg::DIV_NUM_W-1:0]      div_num, div_quo;
	logic [lase_pkg::DIV_DEN_W-1:0]      div_den;
	logic                                div_done;
	logic signed [lase_pkg::TERM_W-1:0]  neg_thr;
	logic                                est_valid;
	logic [lase_pkg::MEAN_W-1:0]         mean_w;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_x_q  <= '0;
			core_y_q  <= '0;
			core_z_q  <= '0;
			axis_nx_q <= '0;
			axis_ny_q <= '0;
			axis_nz_q <= 16'sd16384;
			kappa_q   <= '0;
			radius_q  <= 18'd32000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lase_pkg::REG_CORE_X: core_x_q  <= cfg_data;
				lase_pkg::REG_CORE_Y: core_y_q  <= cfg_data;
				lase_pkg::REG_CORE_Z: core_z_q  <= cfg_data;
				lase_pkg::REG_AXIS_X: axis_nx_q <= cfg_data[lase_pkg::AXIS_W-1:0];
				lase_pkg::REG_AXIS_Y: axis_ny_q <= cfg_data[lase_pkg::AXIS_W-1:0];
				lase_pkg::REG_AXIS_Z: axis_nz_q <= cfg_data[lase_pkg::AXIS_W-1:0];
				lase_pkg::REG_KAPPA:  kappa_q   <= cfg_data[lase_pkg::AXIS_W-1:0];
				lase_pkg::REG_RADIUS: radius_q  <= cfg_data[lase_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Select operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul)
			lase_pkg::MS_NX: begin mul_a = lase_pkg::MUL_A_W'(axis_nx_q); mul_b = lase_pkg::MUL_B_W'(dx_q); end
			lase_pkg::MS_NY: begin mul_a = lase_pkg::MUL_A_W'(axis_ny_q); mul_b = lase_pkg::MUL_B_W'(dy_q); end
			lase_pkg::MS_NZ: begin mul_a = lase_pkg::MUL_A_W'(axis_nz_q); mul_b = lase_pkg::MUL_B_W'(dz_q); end
			lase_pkg::MS_XX: begin mul_a = lase_pkg::MUL_A_W'(dx_q); mul_b = lase_pkg::MUL_B_W'(dx_q); end
			lase_pkg::MS_YY: begin mul_a = lase_pkg::MUL_A_W'(dy_q); mul_b = lase_pkg::MUL_B_W'(dy_q); end
			lase_pkg::MS_ZZ: begin mul_a = lase_pkg::MUL_A_W'(dz_q); mul_b = lase_pkg::MUL_B_W'(dz_q); end
			lase_pkg::MS_PP: begin mul_a = lase_pkg::MUL_A_W'(proj_q); mul_b = lase_pkg::MUL_B_W'(proj_q); end
			lase_pkg::MS_LQ: begin mul_a = lase_pkg::LOG10_2_Q32; mul_b = lase_pkg::MUL_B_W'(l2q_s); end
			lase_pkg::MS_LR: begin mul_a = lase_pkg::LOG10_2_Q32; mul_b = lase_pkg::MUL_B_W'(l2r_s); end
			lase_pkg::MS_K1: begin mul_a = lase_pkg::MUL_A_W'(kappa_q); mul_b = lase_pkg::MUL_B_W'(logr_q); end
			lase_pkg::MS_K2: begin mul_a = lase_pkg::MUL_A_W'(prod_q); mul_b = lase_pkg::MUL_B_W'(logr_q); end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Log2 differences
	assign l2q_s = $signed({2'b00, l2q_q}) - LOG_Q_OFS;
	assign l2r_s = $signed({2'b00, l2p_q}) - $signed({1'b0, l2r0_q, 1'b0});

	// Squared perpendicular distance and pulse selection
	assign dist_u   = lase_pkg::MUL_P_W'(dist_q);
	assign proj2_u  = prod_q;
	assign p_diff   = dist_u - proj2_u;
	assign sel_pass = qok_q && tok_q && (q_q <= lase_pkg::SAT_CHARGE) && (dist_u >= proj2_u)
		&& (p_diff > lase_pkg::NEAR_LIMIT_SQ) && (used_cnt_q < CNT_CAP);

	// Term of one pulse and saturating sum
	assign term  = lase_pkg::TERM_W'(logq_q) + lase_pkg::TERM_W'(logr_q)
		+ lase_pkg::TERM_W'(logr_q) + lase_pkg::TERM_W'(logr_q) + lase_pkg::TERM_W'(kt_q);
	assign sum_w = lase_pkg::TERM_W'(log_sum_q) + term;

	// Pulse and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sx_q   <= s_tdata[19:0];
			sy_q   <= s_tdata[39:20];
			sz_q   <= s_tdata[59:40];
			q_q    <= s_tdata[75:60];
			qok_q  <= s_tuser[0];
			tok_q  <= s_tuser[1];
			last_q <= s_tlast;
		end
		if (cmd.load_diff) begin
			dx_q <= lase_pkg::DIFF_W'(sx_q) - lase_pkg::DIFF_W'(core_x_q);
			dy_q <= lase_pkg::DIFF_W'(sy_q) - lase_pkg::DIFF_W'(core_y_q);
			dz_q <= lase_pkg::DIFF_W'(sz_q) - lase_pkg::DIFF_W'(core_z_q);
		end
		if (cmd.load_proj) begin
			proj_q <= lase_pkg::PROJ_W'(lase_pkg::rnd_shift(64'(dot_q), lase_pkg::PROJ_SHIFT));
		end
		if (cmd.load_p) begin
			p_q <= p_diff[lase_pkg::LOG_IN_W-1:0];
		end
		prod_q <= mul_p;
		case (cmd.acc)
			lase_pkg::AC_DOT_SET:  dot_q  <= lase_pkg::DOT_W'(prod_q);
			lase_pkg::AC_DOT_ADD:  dot_q  <= dot_q + lase_pkg::DOT_W'(prod_q);
			lase_pkg::AC_DIST_SET: dist_q <= lase_pkg::DIST_W'(prod_q);
			lase_pkg::AC_DIST_ADD: dist_q <= dist_q + lase_pkg::DIST_W'(prod_q);
			lase_pkg::AC_LOGQ: logq_q <= lase_pkg::LOG10_W'(
				lase_pkg::rnd_shift(64'(prod_q), LOG_TABLE_BITS + 20));
			lase_pkg::AC_LOGR: logr_q <= lase_pkg::LOG10_W'(
				lase_pkg::rnd_shift(64'(prod_q), LOG_TABLE_BITS + 21));
			lase_pkg::AC_KT: kt_q <= lase_pkg::KT_W'(
				lase_pkg::rnd_shift(64'(prod_q), lase_pkg::KAPPA_SHIFT));
			default: ;
		endcase
		case (cmd.log_cap)
			lase_pkg::LC_Q:  if (log_done) l2q_q  <= log_res;
			lase_pkg::LC_R0: if (log_done) l2r0_q <= log_res;
			lase_pkg::LC_P:  if (log_done) l2p_q  <= log_res;
			default: ;
		endcase
	end

	// Log2 unit input
	assign r0_eff = (radius_q == '0) ? lase_pkg::RADIUS_W'(1) : radius_q;

	always_comb begin
		case (cmd.log_src)
			lase_pkg::LS_Q:  log_x = lase_pkg::LOG_IN_W'(q_q);
			lase_pkg::LS_R0: log_x = lase_pkg::LOG_IN_W'(r0_eff);
			default:         log_x = p_q;
		endcase
	end

	lase_log #(.FRAC_BITS(LOG_TABLE_BITS)) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	// Rounded mean: (2|sum| + n) / 2n
	assign mag     = log_sum_q[lase_pkg::SUM_W-1] ? lase_pkg::SUM_W'(-log_sum_q)
		: lase_pkg::SUM_W'(log_sum_q);
	assign div_num = {mag, 1'b0} + lase_pkg::DIV_NUM_W'(used_cnt_q);
	assign div_den = {used_cnt_q, 1'b0};

	lase_div #(.NUM_W(lase_pkg::DIV_NUM_W), .DEN_W(lase_pkg::DIV_DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Accept test and saturated mean
	assign neg_thr   = -$signed(lase_pkg::TERM_W'({used_cnt_q, 11'b0}));
	assign est_valid = (used_cnt_q >= lase_pkg::MIN_USED) && !zero_seen_q
		&& (lase_pkg::TERM_W'(log_sum_q) >= neg_thr);

	always_comb begin
		if (!est_valid) begin
			mean_w = '0;
		end else if (log_sum_q[lase_pkg::SUM_W-1]) begin
			mean_w = (div_quo > lase_pkg::DIV_NUM_W'(32768)) ? 16'h8000
				: lase_pkg::MEAN_W'(-div_quo);
		end else begin
			mean_w = (div_quo > lase_pkg::DIV_NUM_W'(32767)) ? 16'h7FFF
				: div_quo[lase_pkg::MEAN_W-1:0];
		end
	end

	// Event state: count, accumulate, clear on result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_sum_q   <= '0;
			used_cnt_q  <= '0;
			zero_seen_q <= 1'b0;
		end else if (cmd.emit) begin
			log_sum_q   <= '0;
			used_cnt_q  <= '0;
			zero_seen_q <= 1'b0;
		end else begin
			if (cmd.count) used_cnt_q <= used_cnt_q + 1'b1;
			if (cmd.zero) zero_seen_q <= 1'b1;
			if (cmd.acc == lase_pkg::AC_SUM) begin
				if (sum_w > lase_pkg::TERM_W'(33'sh0_7FFF_FFFF)) begin
					log_sum_q <= 32'sh7FFF_FFFF;
				end else if (sum_w < -lase_pkg::TERM_W'(33'sh0_8000_0000)) begin
					log_sum_q <= 32'sh8000_0000;
				end else begin
					log_sum_q <= lase_pkg::SUM_W'(sum_w);
				end
			end
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			mean_q      <= mean_w;
			cnt_out_q   <= used_cnt_q;
			est_valid_q <= est_valid;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, cnt_out_q, mean_q};
	assign m_tuser  = est_valid_q;

	assign sts.sel_pass = sel_pass;
	assign sts.q_zero   = (q_q == '0);
	assign sts.last     = last_q;
	assign sts.log_done = log_done;
	assign sts.div_done = div_done;
	assign sts.out_free = !m_valid_q || m_tready;

endmodule

[hw/rtl/lase_ctrl.sv]
module lase_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                in_ready,
	input  lase_pkg::lase_sts_t sts,
	output lase_pkg::lase_cmd_t cmd
);

	lase_pkg::lase_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lase_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lase_pkg::ST_IDLE:  if (s_tvalid) state_d = lase_pkg::ST_DIFF;
			lase_pkg::ST_DIFF:  state_d = lase_pkg::ST_M_NX;
			lase_pkg::ST_M_NX:  state_d = lase_pkg::ST_M_NY;
			lase_pkg::ST_M_NY:  state_d = lase_pkg::ST_M_NZ;
			lase_pkg::ST_M_NZ:  state_d = lase_pkg::ST_M_XX;
			lase_pkg::ST_M_XX:  state_d = lase_pkg::ST_M_YY;
			lase_pkg::ST_M_YY:  state_d = lase_pkg::ST_M_ZZ;
			lase_pkg::ST_M_ZZ:  state_d = lase_pkg::ST_PROJ;
			lase_pkg::ST_PROJ:  state_d = lase_pkg::ST_M_PP;
			lase_pkg::ST_M_PP:  state_d = lase_pkg::ST_SEL;
			lase_pkg::ST_SEL: begin
				state_d = (sts.sel_pass && !sts.q_zero) ? lase_pkg::ST_LQ : lase_pkg::ST_FIN;
			end
			lase_pkg::ST_LQ:    state_d = lase_pkg::ST_LQ_W;
			lase_pkg::ST_LQ_W:  if (sts.log_done) state_d = lase_pkg::ST_LR;
			lase_pkg::ST_LR:    state_d = lase_pkg::ST_LR_W;
			lase_pkg::ST_LR_W:  if (sts.log_done) state_d = lase_pkg::ST_LP;
			lase_pkg::ST_LP:    state_d = lase_pkg::ST_LP_W;
			lase_pkg::ST_LP_W:  if (sts.log_done) state_d = lase_pkg::ST_CV_Q;
			lase_pkg::ST_CV_Q:  state_d = lase_pkg::ST_CV_R;
			lase_pkg::ST_CV_R:  state_d = lase_pkg::ST_LOGR;
			lase_pkg::ST_LOGR:  state_d = lase_pkg::ST_K1;
			lase_pkg::ST_K1:    state_d = lase_pkg::ST_K2;
			lase_pkg::ST_K2:    state_d = lase_pkg::ST_KT;
			lase_pkg::ST_KT:    state_d = lase_pkg::ST_SUM;
			lase_pkg::ST_SUM:   state_d = lase_pkg::ST_FIN;
			lase_pkg::ST_FIN:   state_d = sts.last ? lase_pkg::ST_DIV : lase_pkg::ST_IDLE;
			lase_pkg::ST_DIV:   state_d = lase_pkg::ST_DIV_W;
			lase_pkg::ST_DIV_W: if (sts.div_done) state_d = lase_pkg::ST_EMIT;
			lase_pkg::ST_EMIT:  if (sts.out_free) state_d = lase_pkg::ST_IDLE;
			default:            state_d = lase_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd         = '0;
		cmd.mul     = lase_pkg::MS_NONE;
		cmd.acc     = lase_pkg::AC_NONE;
		cmd.log_src = lase_pkg::LS_P;
		cmd.log_cap = lase_pkg::LC_NONE;
		in_ready    = 1'b0;
		unique case (state_q)
			lase_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			lase_pkg::ST_DIFF: cmd.load_diff = 1'b1;
			lase_pkg::ST_M_NX: cmd.mul = lase_pkg::MS_NX;
			lase_pkg::ST_M_NY: begin
				cmd.mul = lase_pkg::MS_NY;
				cmd.acc = lase_pkg::AC_DOT_SET;
			end
			lase_pkg::ST_M_NZ: begin
				cmd.mul = lase_pkg::MS_NZ;
				cmd.acc = lase_pkg::AC_DOT_ADD;
			end
			lase_pkg::ST_M_XX: begin
				cmd.mul = lase_pkg::MS_XX;
				cmd.acc = lase_pkg::AC_DOT_ADD;
			end
			lase_pkg::ST_M_YY: begin
				cmd.mul = lase_pkg::MS_YY;
				cmd.acc = lase_pkg::AC_DIST_SET;
			end
			lase_pkg::ST_M_ZZ: begin
				cmd.mul = lase_pkg::MS_ZZ;
				cmd.acc = lase_pkg::AC_DIST_ADD;
			end
			lase_pkg::ST_PROJ: begin
				cmd.acc       = lase_pkg::AC_DIST_ADD;
				cmd.load_proj = 1'b1;
			end
			lase_pkg::ST_M_PP: cmd.mul = lase_pkg::MS_PP;
			lase_pkg::ST_SEL: begin
				cmd.load_p = 1'b1;
				cmd.count  = sts.sel_pass;
				cmd.zero   = sts.sel_pass && sts.q_zero;
			end
			lase_pkg::ST_LQ: begin
				cmd.log_start = 1'b1;
				cmd.log_src   = lase_pkg::LS_Q;
			end
			lase_pkg::ST_LQ_W: cmd.log_cap = lase_pkg::LC_Q;
			lase_pkg::ST_LR: begin
				cmd.log_start = 1'b1;
				cmd.log_src   = lase_pkg::LS_R0;
			end
			lase_pkg::ST_LR_W: cmd.log_cap = lase_pkg::LC_R0;
			lase_pkg::ST_LP: begin
				cmd.log_start = 1'b1;
				cmd.log_src   = lase_pkg::LS_P;
			end
			lase_pkg::ST_LP_W: cmd.log_cap = lase_pkg::LC_P;
			lase_pkg::ST_CV_Q: cmd.mul = lase_pkg::MS_LQ;
			lase_pkg::ST_CV_R: begin
				cmd.mul = lase_pkg::MS_LR;
				cmd.acc = lase_pkg::AC_LOGQ;
			end
			lase_pkg::ST_LOGR: cmd.acc = lase_pkg::AC_LOGR;
			lase_pkg::ST_K1:   cmd.mul = lase_pkg::MS_K1;
			lase_pkg::ST_K2:   cmd.mul = lase_pkg::MS_K2;
			lase_pkg::ST_KT:   cmd.acc = lase_pkg::AC_KT;
			lase_pkg::ST_SUM:  cmd.acc = lase_pkg::AC_SUM;
			lase_pkg::ST_FIN:  ;
			lase_pkg::ST_DIV:  cmd.div_start = 1'b1;
			lase_pkg::ST_DIV_W: ;
			lase_pkg::ST_EMIT: cmd.emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

[hw/rtl/lateral_amplitude_seed_estimator.sv]
// Lateral amplitude seed estimator.
// Input stream: one detector pulse per request. s_tdata carries sensor x, y, z and
// charge; s_tuser carries the charge and time valid flags; s_tlast ends an event.
// Output stream: one result per event, produced after the request with s_tlast set.
// Configuration: cfg_valid/cfg_index/cfg_data write the core point, axis, kappa and
// reference radius; cfg_ready is always high. Write only while the block is idle.
// Datapath: one pulse at a time through a shared 35x25 multiplier, a log2 unit
// (normalize eight or one bits a cycle, then one fraction bit per squaring) and a
// bit-serial divider. A counted pulse with nonzero charge makes three log2 runs,
// a rejected pulse none. The last pulse of an event adds a 33-step mean division.
// Reset clears the event accumulator, the count, the output valid flag and sets the
// configuration registers to their defaults.
// Stall: the result sits in an output register; the next event's pulses are taken
// while it waits, and only the next result holds until m_tready takes the old one.
module lateral_amplitude_seed_estimator #(
	parameter int MAX_PULSES     = 4096,
	parameter int LOG_TABLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// sensor_x[19:0], sensor_y[39:20], sensor_z[59:40], pulse_charge[75:60], zero pad
	input  logic [lase_pkg::S_DATA_W-1:0]   s_tdata,
	// charge_is_number[0], time_is_number[1]
	input  logic [lase_pkg::S_USER_W-1:0]   s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// mean_log_amplitude[15:0], pulses_counted[28:16], zero pad
	output logic [lase_pkg::M_DATA_W-1:0]   m_tdata,
	// estimate_valid[0]
	output logic [lase_pkg::M_USER_W-1:0]   m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lase_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lase_pkg::CFG_DATA_W-1:0] cfg_data
);

	lase_pkg::lase_cmd_t cmd;
	lase_pkg::lase_sts_t sts;

	assign cfg_ready = 1'b1;

	lase_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lase_dp #(
		.LOG_TABLE_BITS (LOG_TABLE_BITS),
		.MAX_PULSES     (MAX_PULSES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[hw/rtl/lase_chk.sv]
module lase_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lase_pkg::M_DATA_W-1:0] m_tdata,
	input logic [lase_pkg::M_USER_W-1:0] m_tuser
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A valid estimate needs at least five counted pulses
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[28:16] >= 13'd5)
		else $error("valid estimate with too few pulses");

	// A rejected estimate carries a zero mean
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0)
		else $error("rejected estimate with nonzero mean");

	// One pulse at a time: ready drops after each request
	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second pulse taken while busy");

endmodule

bind lateral_amplitude_seed_estimator lase_chk u_lase_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[dv/lase_checker.sv]
`timescale 1ns / 1ps

// Watches the pulse, result and configuration channels, predicts each event
// result and compares it field by field with what the block emits.
module lase_checker #(
	parameter int MAX_PULSES     = 4096,
	parameter int LOG_TABLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [lase_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [lase_pkg::S_USER_W-1:0]   s_tuser,
	input  logic                            s_tlast,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [lase_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic [lase_pkg::M_USER_W-1:0]   m_tuser,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [lase_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lase_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              results_pending
);

	localparam longint LOG10_OF_2 = 64'd1292913987;

	typedef struct {
		logic [lase_pkg::MEAN_W-1:0] mean;
		logic [lase_pkg::CNT_W-1:0]  count;
		logic                        valid;
	} event_result_t;

	event_result_t estimates_q[$];

	// Configuration copy
	logic signed [lase_pkg::POS_W-1:0]  core_x, core_y, core_z;
	logic signed [lase_pkg::AXIS_W-1:0] axis_x, axis_y, axis_z;
	logic signed [lase_pkg::AXIS_W-1:0] kappa;
	logic [lase_pkg::RADIUS_W-1:0]      radius;

	// Event accumulator copy
	longint ev_sum;
	int     ev_count;
	bit     ev_zero_q;

	assign results_pending = estimates_q.size();

	function automatic longint round_half_away(longint v, int s);
		longint unsigned mag;
		mag = v < 0 ? -v : v;
		mag = (mag + (64'd1 << (s - 1))) >> s;
		return v < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	// log2 with LOG_TABLE_BITS fraction bits by repeated squaring
	function automatic longint log2_fixed(longint unsigned x);
		int e;
		longint unsigned m, frac;
		e = 0;
		frac = 0;
		while ((x >> e) > 1) e++;
		m = e >= 30 ? x >> (e - 30) : x << (30 - e);
		for (int i = 0; i < LOG_TABLE_BITS; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return longint'((longint'(e) << LOG_TABLE_BITS) | frac);
	endfunction

	// Fold one pulse into the event; return 1 with the estimate on the last one
	function automatic bit absorb_pulse(input logic [lase_pkg::S_DATA_W-1:0] d,
			input logic [lase_pkg::S_USER_W-1:0] u, input logic lst,
			output event_result_t r);
		longint dx, dy, dz, dot, proj, dist2, proj2, logq, logr, term, mean;
		longint unsigned q, r0, mag;
		int cap;
		bit ok;
		cap = MAX_PULSES > 8191 ? 8191 : MAX_PULSES;
		dx = longint'($signed(d[19:0])) - longint'(core_x);
		dy = longint'($signed(d[39:20])) - longint'(core_y);
		dz = longint'($signed(d[59:40])) - longint'(core_z);
		q = d[75:60];
		dot = longint'(axis_x) * dx + longint'(axis_y) * dy + longint'(axis_z) * dz;
		proj = round_half_away(dot, lase_pkg::PROJ_SHIFT);
		dist2 = dx * dx + dy * dy + dz * dz;
		proj2 = proj * proj;
		ok = u[0] && u[1] && q <= 48000 && dist2 >= proj2 &&
			(dist2 - proj2) > 64'd1024000000 && ev_count < cap;
		if (ok) begin
			ev_count++;
			if (q == 0) begin
				ev_zero_q = 1;
			end else begin
				r0 = radius == 0 ? 1 : radius;
				logq = round_half_away((log2_fixed(q) - (longint'(4) << LOG_TABLE_BITS))
					* LOG10_OF_2, LOG_TABLE_BITS + 20);
				logr = round_half_away((log2_fixed(dist2 - proj2) - 2 * log2_fixed(r0))
					* LOG10_OF_2, LOG_TABLE_BITS + 21);
				term = logq + 3 * logr + round_half_away(longint'(kappa) * logr * logr, 24);
				ev_sum = ev_sum + term;
				if (ev_sum > 64'sd2147483647) ev_sum = 64'sd2147483647;
				if (ev_sum < -64'sd2147483648) ev_sum = -64'sd2147483648;
			end
		end
		if (!lst) return 0;
		r.valid = ev_count >= 5 && !ev_zero_q && ev_sum >= -2048 * longint'(ev_count);
		mean = 0;
		if (r.valid) begin
			mag = ev_sum < 0 ? -ev_sum : ev_sum;
			mag = (2 * mag + ev_count) / (2 * longint'(ev_count));
			mean = ev_sum < 0 ? -longint'(mag) : longint'(mag);
			if (mean > 32767) mean = 32767;
			if (mean < -32768) mean = -32768;
		end
		r.mean = mean[15:0];
		r.count = ev_count[12:0];
		ev_sum = 0;
		ev_count = 0;
		ev_zero_q = 0;
		return 1;
	endfunction

	task automatic flag_mismatch(string what, longint exp_v, longint got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch %s: expected %0d actual %0d", $realtime, what, exp_v, got_v);
	endtask

	// Track configuration, predict on accepted pulses, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		event_result_t r, e;
		if (!arst_n) begin
			core_x <= '0;
			core_y <= '0;
			core_z <= '0;
			axis_x <= '0;
			axis_y <= '0;
			axis_z <= 16'sd16384;
			kappa <= '0;
			radius <= 18'd32000;
			ev_sum = 0;
			ev_count = 0;
			ev_zero_q = 0;
			estimates_q.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lase_pkg::REG_CORE_X: core_x <= cfg_data[19:0];
					lase_pkg::REG_CORE_Y: core_y <= cfg_data[19:0];
					lase_pkg::REG_CORE_Z: core_z <= cfg_data[19:0];
					lase_pkg::REG_AXIS_X: axis_x <= cfg_data[15:0];
					lase_pkg::REG_AXIS_Y: axis_y <= cfg_data[15:0];
					lase_pkg::REG_AXIS_Z: axis_z <= cfg_data[15:0];
					lase_pkg::REG_KAPPA:  kappa  <= cfg_data[15:0];
					lase_pkg::REG_RADIUS: radius <= cfg_data[17:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (absorb_pulse(s_tdata, s_tuser, s_tlast, r))
					estimates_q.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				if (estimates_q.size() == 0) begin
					flag_mismatch("unexpected result, mean", 0, m_tdata[15:0]);
				end else begin
					e = estimates_q.pop_front();
					if (m_tdata[15:0] !== e.mean)
						flag_mismatch("mean_log_amplitude", e.mean, m_tdata[15:0]);
					if (m_tdata[28:16] !== e.count)
						flag_mismatch("pulses_counted", e.count, m_tdata[28:16]);
					if (m_tuser[0] !== e.valid)
						flag_mismatch("estimate_valid", e.valid, m_tuser[0]);
				end
			end
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam longint CYCLE_LIMIT = 6000000;
	localparam int SETTLE = 250;

	logic clk;
	logic arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [lase_pkg::S_DATA_W-1:0] s_tdata;
	logic [lase_pkg::S_USER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [lase_pkg::M_DATA_W-1:0] m_tdata;
	logic [lase_pkg::M_USER_W-1:0] m_tuser;
	logic cfg_valid, cfg_ready;
	logic [lase_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lase_pkg::CFG_DATA_W-1:0] cfg_data;

	int     mismatches;
	int     results_pending;
	int     tx_idle_pct;
	int     rx_idle_pct;
	longint cycles = 0;

	lateral_amplitude_seed_estimator DUT (.*);

	lase_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [lase_pkg::CFG_IDX_W-1:0] idx,
			logic [lase_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain outstanding results and let the datapath settle before a register write
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (results_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_geometry(int cx, int cy, int cz, int nx, int ny, int nz,
			int kap, int r0);
		wait_idle();
		write_reg(lase_pkg::REG_CORE_X, lase_pkg::CFG_DATA_W'(cx));
		write_reg(lase_pkg::REG_CORE_Y, lase_pkg::CFG_DATA_W'(cy));
		write_reg(lase_pkg::REG_CORE_Z, lase_pkg::CFG_DATA_W'(cz));
		write_reg(lase_pkg::REG_AXIS_X, {4'($urandom), 16'(nx)});
		write_reg(lase_pkg::REG_AXIS_Y, {4'($urandom), 16'(ny)});
		write_reg(lase_pkg::REG_AXIS_Z, {4'($urandom), 16'(nz)});
		write_reg(lase_pkg::REG_KAPPA,  {4'($urandom), 16'(kap)});
		write_reg(lase_pkg::REG_RADIUS, {2'($urandom), 18'(r0)});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pulse(int x, int y, int z, int q, bit qok, bit tok, bit lst);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, 16'(q), 20'(z), 20'(y), 20'(x)};
		s_tuser <= {tok, qok};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
	endtask

	// Mostly selectable pulses, some noise on flags and charge
	task automatic send_random_event(int len, bit far_only);
		int x, q;
		for (int i = 0; i < len; i++) begin
			x = $urandom_range(0, 1048575) - 524288;
			if (far_only) x = (x < 0 ? -40000 : 40000) + x / 2;
			case ($urandom_range(0, 19))
				0: q = 0;
				1: q = $urandom_range(48001, 65535);
				2: q = $urandom_range(1, 20);
				default: q = $urandom_range(1, 48000);
			endcase
			send_pulse(x, $urandom_range(0, 1048575) - 524288,
				$urandom_range(0, 1048575) - 524288, q,
				far_only || $urandom_range(0, 15) != 0,
				far_only || $urandom_range(0, 15) != 0, i == len - 1);
		end
	endtask

	task automatic random_phase(int events);
		for (int e = 0; e < events; e++)
			send_random_event($urandom_range(0, 9) == 0 ? $urandom_range(1, 4) :
				$urandom_range(5, 12), 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_pct = 21;
		rx_idle_pct = 84;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset geometry, axis along z, so R is the horizontal distance
		send_pulse(-524288, -524288, -524288, 48000, 1, 1, 0);
		send_pulse(524287, 524287, 524287, 1, 1, 1, 0);
		send_pulse(32000, 0, 0, 100, 1, 1, 0);      // exactly at the cut, dropped
		send_pulse(32001, 0, 0, 100, 1, 1, 0);
		send_pulse(0, 40000, 0, 48001, 1, 1, 0);    // charge over saturation
		send_pulse(0, 40000, 0, 65535, 1, 1, 0);
		send_pulse(0, -40000, 0, 500, 0, 1, 0);
		send_pulse(0, -40000, 0, 500, 1, 0, 0);
		send_pulse(100, 100, 524287, 500, 1, 1, 0); // on the axis, dropped
		send_pulse(-300000, 1000, 0, 7, 1, 1, 0);
		send_pulse(200000, -90000, 0, 16, 1, 1, 1);
		// zero charge on a counted pulse rejects the event
		send_pulse(100000, 0, 0, 0, 1, 1, 0);
		for (int i = 0; i < 5; i++) send_pulse(150000, i * 1000, 0, 3000, 1, 1, i == 4);
		// short event, too few counted
		send_pulse(100000, 0, 0, 3000, 1, 1, 0);
		send_pulse(0, 0, 0, 3000, 1, 1, 1);

		// non-unit axis: projection exceeds the distance
		set_geometry(0, 0, 0, 16384, 16384, 16384, 0, 32000);
		for (int i = 0; i < 4; i++) send_pulse(200000, 200000, 200000, 800, 1, 1, 0);
		send_pulse(300000, -10000, 0, 800, 1, 1, 1);
		random_phase(10);

		// extremes of the core, kappa and radius registers, zero reference radius
		set_geometry(-524288, 524287, -524288, -16384, 0, 0, 32767, 0);
		random_phase(12);
		set_geometry(524287, -524288, 524287, 0, -16384, 0, -32768, 262143);
		random_phase(12);

		tx_idle_pct = 84;
		rx_idle_pct = 21;
		set_geometry(1000, -2000, 3000, 0, 0, -16384, -32768, 256);
		random_phase(12);
		set_geometry($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
			0, 9459, 9459, 9459, $urandom_range(0, 65535) - 32768,
			$urandom_range(256, 262143));
		random_phase(12);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_geometry(0, 0, 0, 11585, 0, 11585, 32767, 32000);
		random_phase(8);
		// long event of far pulses, all with both flags set
		set_geometry(0, 0, 0, 0, 0, 16384, 0, 32000);
		send_random_event(40, 1'b1);
		random_phase(4);

		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		while (results_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && results_pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
